/* rtl/ssit_pkg.sv */
// Shared widths, payload types, outcode constants and pipeline stage records.
package ssit_pkg;

  localparam int CW = 32;
  localparam int SW = CW - 1;
  localparam int DW = CW + 2;
  localparam int EW = DW + 1;
  localparam int PW = 2 * DW;
  localparam int QW = SW + EW + 1;
  localparam int NW = PW + 2;

  localparam logic [3:0] EDGE_RIGHT  = 4'h1;
  localparam logic [3:0] EDGE_LEFT   = 4'h2;
  localparam logic [3:0] EDGE_TOP    = 4'h4;
  localparam logic [3:0] EDGE_BOTTOM = 4'h8;

  localparam logic [3:0] CORNER_PP = 4'h1;
  localparam logic [3:0] CORNER_PM = 4'h2;
  localparam logic [3:0] CORNER_MP = 4'h4;
  localparam logic [3:0] CORNER_MM = 4'h8;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic        [SW-1:0] side_t;
  typedef logic signed [DW-1:0] dbl_t;
  typedef logic signed [EW-1:0] dif_t;
  typedef logic signed [PW-1:0] mul_t;
  typedef logic signed [QW-1:0] sc_t;
  typedef logic signed [NW-1:0] num_t;

  typedef struct packed {
    logic       early;
    logic       reject;
    logic       dnz;
    logic       enz;
    logic [3:0] span;
  } flag_t;

  typedef struct packed {
    dbl_t  x1;
    dbl_t  y1;
    dbl_t  x2;
    dbl_t  y2;
    side_t s;
  } off_t;

  typedef struct packed {
    flag_t flag;
    dbl_t  x1;
    dbl_t  y1;
    dbl_t  x2;
    dbl_t  y2;
    side_t s;
    dif_t  d;
    dif_t  e;
  } cls_t;

  typedef struct packed {
    flag_t flag;
    mul_t  pc1;
    mul_t  pc2;
    sc_t   pd;
    sc_t   pe;
  } prd_t;

  typedef struct packed {
    flag_t flag;
    num_t  c;
    sc_t   pd;
    sc_t   pe;
    sc_t   ld;
    sc_t   nld;
    sc_t   le;
    sc_t   nle;
  } lim_t;

  typedef struct packed {
    flag_t flag;
    num_t  n_rt;
    num_t  n_lt;
    num_t  n_tp;
    num_t  n_bt;
    sc_t   ld;
    sc_t   nld;
    sc_t   le;
    sc_t   nle;
  } sum_t;

endpackage

/* rtl/ssit_item_if.sv */
// Input channel: one segment and one square per beat.
interface ssit_item_if;
  logic            valid;
  logic            ready;
  ssit_pkg::coord_t center_x;
  ssit_pkg::coord_t center_y;
  ssit_pkg::side_t  side_length;
  ssit_pkg::coord_t start_x;
  ssit_pkg::coord_t start_y;
  ssit_pkg::coord_t end_x;
  ssit_pkg::coord_t end_y;

  modport source (
    output valid, center_x, center_y, side_length, start_x, start_y, end_x, end_y,
    input  ready
  );
  modport sink (
    input  valid, center_x, center_y, side_length, start_x, start_y, end_x, end_y,
    output ready
  );
endinterface

/* rtl/ssit_result_if.sv */
// Output channel: one touch flag per beat.
interface ssit_result_if;
  logic valid;
  logic ready;
  logic touches;

  modport source (output valid, touches, input ready);
  modport sink (input valid, touches, output ready);
endinterface

/* rtl/ssit_offset.sv */
// Stage one: endpoint offsets from the square centre, doubled.
module ssit_offset (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  ssit_pkg::coord_t center_x,
  input  ssit_pkg::coord_t center_y,
  input  ssit_pkg::side_t  side_length,
  input  ssit_pkg::coord_t start_x,
  input  ssit_pkg::coord_t start_y,
  input  ssit_pkg::coord_t end_x,
  input  ssit_pkg::coord_t end_y,
  output logic             out_valid,
  output ssit_pkg::off_t   out_data
);

  ssit_pkg::dbl_t dx1, dy1, dx2, dy2;
  ssit_pkg::off_t data_next;

  assign dx1 = ssit_pkg::dbl_t'(start_x) - ssit_pkg::dbl_t'(center_x);
  assign dy1 = ssit_pkg::dbl_t'(start_y) - ssit_pkg::dbl_t'(center_y);
  assign dx2 = ssit_pkg::dbl_t'(end_x) - ssit_pkg::dbl_t'(center_x);
  assign dy2 = ssit_pkg::dbl_t'(end_y) - ssit_pkg::dbl_t'(center_y);

  always_comb begin
    data_next.x1 = dx1 <<< 1;
    data_next.y1 = dy1 <<< 1;
    data_next.x2 = dx2 <<< 1;
    data_next.y2 = dy2 <<< 1;
    data_next.s  = side_length;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= data_next;
    end
  end

endmodule

/* rtl/ssit_classify.sv */
// Stage two: edge and corner outcodes, trivial accept and reject, segment deltas.
module ssit_classify (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  ssit_pkg::off_t in_data,
  output logic           out_valid,
  output ssit_pkg::cls_t out_data
);

  function automatic logic [3:0] edge_bits(input ssit_pkg::dbl_t x, input ssit_pkg::dbl_t y,
                                           input ssit_pkg::dbl_t sp,
                                           input ssit_pkg::dbl_t nsp);
    logic [3:0] c;
    c = '0;
    if (x > sp)  c = c | ssit_pkg::EDGE_RIGHT;
    if (x < nsp) c = c | ssit_pkg::EDGE_LEFT;
    if (y > sp)  c = c | ssit_pkg::EDGE_TOP;
    if (y < nsp) c = c | ssit_pkg::EDGE_BOTTOM;
    return c;
  endfunction

  function automatic logic [3:0] corner_bits(input ssit_pkg::dbl_t x,
                                             input ssit_pkg::dbl_t y,
                                             input ssit_pkg::dif_t s2,
                                             input ssit_pkg::dif_t ns2);
    ssit_pkg::dif_t sum;
    ssit_pkg::dif_t dif;
    logic [3:0]     c;
    sum = ssit_pkg::dif_t'(x) + ssit_pkg::dif_t'(y);
    dif = ssit_pkg::dif_t'(x) - ssit_pkg::dif_t'(y);
    c = '0;
    if (sum > s2)  c = c | ssit_pkg::CORNER_PP;
    if (dif > s2)  c = c | ssit_pkg::CORNER_PM;
    if (dif < ns2) c = c | ssit_pkg::CORNER_MP;
    if (sum < ns2) c = c | ssit_pkg::CORNER_MM;
    return c;
  endfunction

  ssit_pkg::dbl_t sp, nsp;
  ssit_pkg::dif_t s2, ns2;
  logic [3:0]     c1, c2, k1, k2;
  ssit_pkg::cls_t data_next;

  assign sp  = ssit_pkg::dbl_t'(in_data.s);
  assign nsp = -sp;
  assign s2  = ssit_pkg::dif_t'({in_data.s, 1'b0});
  assign ns2 = -s2;

  assign c1 = edge_bits(in_data.x1, in_data.y1, sp, nsp);
  assign c2 = edge_bits(in_data.x2, in_data.y2, sp, nsp);
  assign k1 = corner_bits(in_data.x1, in_data.y1, s2, ns2);
  assign k2 = corner_bits(in_data.x2, in_data.y2, s2, ns2);

  always_comb begin
    data_next.x1          = in_data.x1;
    data_next.y1          = in_data.y1;
    data_next.x2          = in_data.x2;
    data_next.y2          = in_data.y2;
    data_next.s           = in_data.s;
    data_next.d           = ssit_pkg::dif_t'(in_data.x2) - ssit_pkg::dif_t'(in_data.x1);
    data_next.e           = ssit_pkg::dif_t'(in_data.y2) - ssit_pkg::dif_t'(in_data.y1);
    data_next.flag.early  = (c1 == '0) || (c2 == '0);
    data_next.flag.reject = ((c1 & c2) != '0) || ((k1 & k2) != '0);
    data_next.flag.dnz    = in_data.x2 != in_data.x1;
    data_next.flag.enz    = in_data.y2 != in_data.y1;
    data_next.flag.span   = c1 | c2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= data_next;
    end
  end

endmodule

/* rtl/ssit_cross.sv */
// Stages three to five: cross product, scaled deltas, limits and edge crossing numerators.
module ssit_cross (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  ssit_pkg::cls_t in_data,
  output logic           out_valid,
  output ssit_pkg::sum_t out_data
);

  ssit_pkg::sc_t  ss;
  ssit_pkg::prd_t prd_next, prd;
  ssit_pkg::lim_t lim_next, lim;
  ssit_pkg::sum_t sum_next;
  logic           prd_valid, lim_valid;

  assign ss = ssit_pkg::sc_t'(in_data.s);

  always_comb begin
    prd_next.flag = in_data.flag;
    prd_next.pc1  = ssit_pkg::mul_t'(in_data.y1) * ssit_pkg::mul_t'(in_data.x2);
    prd_next.pc2  = ssit_pkg::mul_t'(in_data.x1) * ssit_pkg::mul_t'(in_data.y2);
    prd_next.pd   = ss * ssit_pkg::sc_t'(in_data.d);
    prd_next.pe   = ss * ssit_pkg::sc_t'(in_data.e);
  end

  always_comb begin
    lim_next.flag = prd.flag;
    lim_next.c    = ssit_pkg::num_t'(prd.pc1) - ssit_pkg::num_t'(prd.pc2);
    lim_next.pd   = prd.pd;
    lim_next.pe   = prd.pe;
    lim_next.ld   = prd.pd[ssit_pkg::QW-1] ? -prd.pd : prd.pd;
    lim_next.nld  = prd.pd[ssit_pkg::QW-1] ? prd.pd : -prd.pd;
    lim_next.le   = prd.pe[ssit_pkg::QW-1] ? -prd.pe : prd.pe;
    lim_next.nle  = prd.pe[ssit_pkg::QW-1] ? prd.pe : -prd.pe;
  end

  always_comb begin
    sum_next.flag = lim.flag;
    sum_next.n_rt = lim.c + ssit_pkg::num_t'(lim.pe);
    sum_next.n_lt = lim.c - ssit_pkg::num_t'(lim.pe);
    sum_next.n_tp = lim.c - ssit_pkg::num_t'(lim.pd);
    sum_next.n_bt = lim.c + ssit_pkg::num_t'(lim.pd);
    sum_next.ld   = lim.ld;
    sum_next.nld  = lim.nld;
    sum_next.le   = lim.le;
    sum_next.nle  = lim.nle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prd_valid <= 1'b0;
      lim_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      prd_valid <= in_valid;
      lim_valid <= prd_valid;
      out_valid <= lim_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prd      <= prd_next;
      lim      <= lim_next;
      out_data <= sum_next;
    end
  end

endmodule

/* rtl/ssit_decide.sv */
// Stage six: range checks on each spanned edge and the registered touch flag.
module ssit_decide (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  ssit_pkg::sum_t in_data,
  output logic           out_valid,
  output logic           touches
);

  logic in_rt, in_lt, in_tp, in_bt;
  logic hit_rt, hit_lt, hit_tp, hit_bt;
  logic touches_next;

  assign in_rt = (in_data.n_rt <= ssit_pkg::num_t'(in_data.ld)) &&
                 (in_data.n_rt >= ssit_pkg::num_t'(in_data.nld));
  assign in_lt = (in_data.n_lt <= ssit_pkg::num_t'(in_data.ld)) &&
                 (in_data.n_lt >= ssit_pkg::num_t'(in_data.nld));
  assign in_tp = (in_data.n_tp <= ssit_pkg::num_t'(in_data.le)) &&
                 (in_data.n_tp >= ssit_pkg::num_t'(in_data.nle));
  assign in_bt = (in_data.n_bt <= ssit_pkg::num_t'(in_data.le)) &&
                 (in_data.n_bt >= ssit_pkg::num_t'(in_data.nle));

  assign hit_rt = ((in_data.flag.span & ssit_pkg::EDGE_RIGHT) != '0) &&
                  in_data.flag.dnz && in_rt;
  assign hit_lt = ((in_data.flag.span & ssit_pkg::EDGE_LEFT) != '0) &&
                  in_data.flag.dnz && in_lt;
  assign hit_tp = ((in_data.flag.span & ssit_pkg::EDGE_TOP) != '0) &&
                  in_data.flag.enz && in_tp;
  assign hit_bt = ((in_data.flag.span & ssit_pkg::EDGE_BOTTOM) != '0) &&
                  in_data.flag.enz && in_bt;

  assign touches_next = in_data.flag.early ||
                        (!in_data.flag.reject && (hit_rt || hit_lt || hit_tp || hit_bt));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      touches <= touches_next;
    end
  end

endmodule

/* rtl/segment_square_intersect_test.sv */
// Top level: segment against axis-aligned square touch test, six-stage pipeline.
//
// Accepts one segment/square beat every clock while the output side is ready, and returns
// one touches beat per input, in order. Stages: centre offsets, outcodes with trivial
// accept/reject, the four signed products (two 68-bit, two 67-bit), cross product and
// limits, crossing numerators, range checks into the output register. The whole pipeline
// holds while the output register is full and not taken, so input ready follows output
// ready combinationally. touches is 1 when the segment meets the closed square.
module segment_square_intersect_test (
  input  logic             clk,
  input  logic             rst,
  ssit_item_if.sink        item,
  ssit_result_if.source    result
);

  logic           adv;
  logic           off_valid, cls_valid, sum_valid;
  ssit_pkg::off_t off_data;
  ssit_pkg::cls_t cls_data;
  ssit_pkg::sum_t sum_data;

  assign adv        = !result.valid || result.ready;
  assign item.ready = adv;

  ssit_offset u_offset (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (item.valid),
    .center_x    (item.center_x),
    .center_y    (item.center_y),
    .side_length (item.side_length),
    .start_x     (item.start_x),
    .start_y     (item.start_y),
    .end_x       (item.end_x),
    .end_y       (item.end_y),
    .out_valid   (off_valid),
    .out_data    (off_data)
  );

  ssit_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (off_valid),
    .in_data   (off_data),
    .out_valid (cls_valid),
    .out_data  (cls_data)
  );

  ssit_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (cls_valid),
    .in_data   (cls_data),
    .out_valid (sum_valid),
    .out_data  (sum_data)
  );

  ssit_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sum_valid),
    .in_data   (sum_data),
    .out_valid (result.valid),
    .touches   (result.touches)
  );

endmodule
